// ----- src/dlr_pkg.sv -----
package dlr_pkg;

  localparam int FUNC_W = 3;
  localparam int VALUE_W = 32;
  localparam int STATUS_W = 2;
  localparam int DEPTH_DEF = 64;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR   = 3'd0,
    FN_PUSH    = 3'd1,
    FN_REVERSE = 3'd2,
    FN_DELETE  = 3'd3,
    FN_EMIT    = 3'd4
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ELEM     = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_ERROR    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_t;

endpackage

// ----- src/dlr_ram.sv -----
module dlr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- src/deque_with_lazy_reverse_core.sv -----
// Double-ended queue over a ring store held in one single-port-read RAM. Clear, push,
// reverse and delete leave the input ready, and it stays ready while earlier results
// drain. An emit holds the input while it reads its elements in turn through the store's
// single read port (or gives one empty, error or overflow result), and longer while the
// output stalls; results leave through a two-deep pipeline at up to one item per cycle
// when not stalled. Reverse only flips a direction flag, so no data move in the store.
module deque_with_lazy_reverse_core #(
  parameter int DEPTH = dlr_pkg::DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [dlr_pkg::FUNC_W-1:0]          in_func,
  input  logic signed [dlr_pkg::VALUE_W-1:0]  in_value,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [dlr_pkg::STATUS_W-1:0]        out_status,
  output logic signed [dlr_pkg::VALUE_W-1:0]  out_element,
  output logic                                out_last
);

  import dlr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW:0] DEPTH_S = (AW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [CW-1:0] ONE_C = CW'(1);

  typedef enum logic {S_IDLE, S_EMIT} state_t;

  state_t        state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] occ_r, occ_nxt;
  logic          rev_r, rev_nxt;
  logic          err_r, err_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  logic          s1_valid_r, s1_valid_nxt;
  status_t       s1_status_r;
  logic          s1_last_r;
  logic          out_valid_r, out_valid_nxt;
  status_t       out_status_r;
  logic [VALUE_W-1:0] out_element_r;
  logic          out_last_r;

  logic               accept, move, fire, stream;
  logic               ram_we, ram_re;
  logic [AW-1:0]      ram_waddr, ram_raddr;
  logic [VALUE_W-1:0] ram_rdata;
  logic [CW-1:0]      rd_off;
  status_t            fire_status;
  logic               fire_last;
  func_t              func;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [AW-1:0] o);
    logic [AW:0] s;
    s = {1'b0, h} + {1'b0, o};
    if (s >= DEPTH_S) begin
      s = s - DEPTH_S;
    end
    return s[AW-1:0];
  endfunction

  assign func     = func_t'(in_func);
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign move     = s1_valid_r && (!out_valid_r || out_ready);
  assign fire     = (state_r == S_EMIT) && (!s1_valid_r || move);
  assign stream   = !err_r && !ovf_r && (occ_r != '0);

  assign rd_off    = rev_r ? (occ_r - ONE_C - cnt_r) : cnt_r;
  assign ram_raddr = slot(head_r, rd_off[AW-1:0]);
  assign ram_re    = fire && stream;
  assign ram_waddr = slot(head_r, occ_r[AW-1:0]);
  assign ram_we    = accept && !err_r && (func == FN_PUSH) && (occ_r != DEPTH_C);

  always_comb begin
    if (err_r) begin
      fire_status = ST_ERROR;
    end else if (ovf_r) begin
      fire_status = ST_OVERFLOW;
    end else if (occ_r == '0) begin
      fire_status = ST_EMPTY;
    end else begin
      fire_status = ST_ELEM;
    end
    fire_last = !stream || (cnt_r == occ_r - ONE_C);
  end

  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    occ_nxt   = occ_r;
    rev_nxt   = rev_r;
    err_nxt   = err_r;
    ovf_nxt   = ovf_r;
    cnt_nxt   = cnt_r;
    if (accept) begin
      if (func == FN_CLEAR) begin
        head_nxt = '0;
        occ_nxt  = '0;
        rev_nxt  = 1'b0;
        err_nxt  = 1'b0;
        ovf_nxt  = 1'b0;
      end else if (func == FN_EMIT) begin
        state_nxt = S_EMIT;
        cnt_nxt   = '0;
      end else if (!err_r) begin
        unique case (func)
          FN_PUSH: begin
            if (occ_r == DEPTH_C) begin
              ovf_nxt = 1'b1;
            end else begin
              occ_nxt = occ_r + ONE_C;
            end
          end
          FN_REVERSE: begin
            rev_nxt = !rev_r;
          end
          FN_DELETE: begin
            if (occ_r == '0) begin
              err_nxt = 1'b1;
            end else begin
              if (!rev_r) begin
                head_nxt = slot(head_r, AW'(1));
              end
              occ_nxt = occ_r - ONE_C;
            end
          end
          default: begin
          end
        endcase
      end
    end
    if (fire) begin
      cnt_nxt = cnt_r + ONE_C;
      if (fire_last) begin
        state_nxt = S_IDLE;
      end
    end
  end

  always_comb begin
    s1_valid_nxt = fire ? 1'b1 : (move ? 1'b0 : s1_valid_r);
    out_valid_nxt = move ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      s1_status_r <= fire_status;
      s1_last_r   <= fire_last;
    end
    if (move) begin
      out_status_r  <= s1_status_r;
      out_element_r <= (s1_status_r == ST_ELEM) ? ram_rdata : '0;
      out_last_r    <= s1_last_r;
    end
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      occ_r       <= '0;
      rev_r       <= 1'b0;
      err_r       <= 1'b0;
      ovf_r       <= 1'b0;
      cnt_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      occ_r       <= occ_nxt;
      rev_r       <= rev_nxt;
      err_r       <= err_nxt;
      ovf_r       <= ovf_nxt;
      cnt_r       <= cnt_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  dlr_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_last    = out_last_r;

endmodule

// ----- src/dlr_checker.sv -----
module dlr_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic [dlr_pkg::FUNC_W-1:0]          in_func,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic [dlr_pkg::STATUS_W-1:0]        out_status,
  input logic signed [dlr_pkg::VALUE_W-1:0]  out_element,
  input logic                                out_last
);

  import dlr_pkg::*;

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Output valid after reset.");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status)
      && $stable(out_element) && $stable(out_last))
    else $error("Stalled output item changed.");

  a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_ELEM) |-> out_last && (out_element == '0))
    else $error("Status item is not a final zero item.");

  a_emit_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_func == FN_EMIT) |=> !in_ready)
    else $error("Input taken during an emit run.");

endmodule

bind deque_with_lazy_reverse_core dlr_checker u_dlr_checker (.*);

// ----- dv/tb.sv -----
module tb;
  import dlr_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 270;
  localparam int MAX_PRINTED = 100;

  typedef struct {
    logic [FUNC_W-1:0]         func;
    logic signed [VALUE_W-1:0] value;
    bit                        hold;
  } deque_cmd_t;

  typedef struct {
    status_t                   status;
    logic signed [VALUE_W-1:0] element;
    logic                      last;
  } deque_result_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [FUNC_W-1:0]         in_func = '0;
  logic signed [VALUE_W-1:0] in_value = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [STATUS_W-1:0]       out_status;
  logic signed [VALUE_W-1:0] out_element;
  logic                      out_last;

  deque_cmd_t    pending_cmds[$];
  deque_result_t pending_results[$];
  int            mismatches = 0;
  int            cycle_count = 0;
  int            stim_count = 0;

  // Shadow copy of the deque state.
  logic signed [VALUE_W-1:0] dq_mem [DEPTH];
  int                        dq_head = 0;
  int                        dq_count = 0;
  bit                        dq_rev = 1'b0;
  bit                        dq_err = 1'b0;
  bit                        dq_ovf = 1'b0;

  deque_with_lazy_reverse_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_func    (in_func),
    .in_value   (in_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_status (out_status),
    .out_element(out_element),
    .out_last   (out_last)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    end
  endtask

  task automatic add_result(input status_t status, input logic signed [VALUE_W-1:0] element,
                            input logic last);
    deque_result_t r;
    r.status = status;
    r.element = element;
    r.last = last;
    pending_results.insert(pending_results.size(), r);
  endtask

  task automatic apply_command(input logic [FUNC_W-1:0] func,
                               input logic signed [VALUE_W-1:0] value);
    int off;
    if (func == FN_CLEAR) begin
      dq_head = 0;
      dq_count = 0;
      dq_rev = 1'b0;
      dq_err = 1'b0;
      dq_ovf = 1'b0;
    end else if (func == FN_EMIT) begin
      if (dq_err) begin
        add_result(ST_ERROR, '0, 1'b1);
      end else if (dq_ovf) begin
        add_result(ST_OVERFLOW, '0, 1'b1);
      end else if (dq_count == 0) begin
        add_result(ST_EMPTY, '0, 1'b1);
      end else begin
        for (int k = 0; k < dq_count; k++) begin
          off = dq_rev ? (dq_count - 1 - k) : k;
          add_result(ST_ELEM, dq_mem[(dq_head + off) % DEPTH], (k + 1 == dq_count));
        end
      end
    end else if (!dq_err) begin
      case (func)
        FN_PUSH: begin
          if (dq_count >= DEPTH) begin
            dq_ovf = 1'b1;
          end else begin
            dq_mem[(dq_head + dq_count) % DEPTH] = value;
            dq_count++;
          end
        end
        FN_REVERSE: begin
          dq_rev = !dq_rev;
        end
        FN_DELETE: begin
          if (dq_count == 0) begin
            dq_err = 1'b1;
          end else begin
            if (!dq_rev) dq_head = (dq_head + 1) % DEPTH;
            dq_count--;
          end
        end
        default: ;
      endcase
    end
  endtask

  function automatic logic signed [VALUE_W-1:0] rand_value();
    case ($urandom_range(0, 11))
      0: return {1'b1, {(VALUE_W-1){1'b0}}};
      1: return {1'b0, {(VALUE_W-1){1'b1}}};
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [FUNC_W-1:0] unused_code();
    return FN_EMIT + FUNC_W'($urandom_range(1, 3));
  endfunction

  task automatic queue_cmd(input logic [FUNC_W-1:0] func, input logic signed [VALUE_W-1:0] value);
    deque_cmd_t c;
    c.func = func;
    c.value = value;
    c.hold = 1'b0;
    pending_cmds.insert(pending_cmds.size(), c);
    if (func <= FN_EMIT) stim_count++;
  endtask

  task automatic queue_hold();
    deque_cmd_t c;
    c.func = FN_CLEAR;
    c.value = '0;
    c.hold = 1'b1;
    pending_cmds.insert(pending_cmds.size(), c);
  endtask

  task automatic build_stimulus();
    int n_ops;
    int live;
    int pick;
    queue_cmd(FN_EMIT, rand_value());
    queue_cmd(FN_PUSH, {1'b1, {(VALUE_W-1){1'b0}}});
    queue_cmd(FN_PUSH, {1'b0, {(VALUE_W-1){1'b1}}});
    queue_cmd(FN_PUSH, '0);
    queue_cmd(FN_PUSH, '1);
    queue_cmd(FN_EMIT, rand_value());
    queue_cmd(FN_REVERSE, rand_value());
    queue_cmd(FN_EMIT, rand_value());
    queue_cmd(FN_DELETE, rand_value());
    queue_cmd(FN_EMIT, rand_value());
    queue_cmd(FN_REVERSE, rand_value());
    queue_cmd(FN_DELETE, rand_value());
    queue_cmd(FN_EMIT, rand_value());
    queue_cmd(FN_EMIT + 3'd1, rand_value());
    queue_cmd(FN_EMIT + 3'd2, rand_value());
    queue_cmd(FN_EMIT + 3'd3, rand_value());
    queue_cmd(FN_DELETE, rand_value());
    queue_cmd(FN_DELETE, rand_value());
    queue_cmd(FN_DELETE, rand_value());
    queue_cmd(FN_PUSH, rand_value());
    queue_cmd(FN_REVERSE, rand_value());
    queue_cmd(FN_EMIT, rand_value());
    queue_cmd(FN_CLEAR, rand_value());
    queue_cmd(FN_EMIT, rand_value());
    queue_hold();

    // Fill the store, overflow it, wrap the ring, then drain it into an error.
    queue_cmd(FN_CLEAR, rand_value());
    repeat (DEPTH) queue_cmd(FN_PUSH, rand_value());
    queue_cmd(FN_EMIT, rand_value());
    queue_cmd(FN_PUSH, rand_value());
    queue_cmd(FN_EMIT, rand_value());
    queue_cmd(FN_REVERSE, rand_value());
    repeat (20) begin
      queue_cmd(FN_DELETE, rand_value());
      if ($urandom_range(0, 5) == 0) queue_cmd(FN_REVERSE, rand_value());
    end
    repeat (15) queue_cmd(FN_PUSH, rand_value());
    queue_cmd(FN_EMIT, rand_value());
    repeat (DEPTH - 20 + 15 + 1) queue_cmd(FN_DELETE, rand_value());
    queue_cmd(FN_EMIT, rand_value());
    queue_cmd(FN_PUSH, rand_value());
    queue_cmd(FN_CLEAR, rand_value());
    queue_cmd(FN_EMIT, rand_value());

    live = 0;
    while (stim_count < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) queue_hold();
      if ($urandom_range(0, 9) < 8) begin
        if ($urandom_range(0, 2) == 0) begin
          queue_cmd(FN_CLEAR, rand_value());
          live = 0;
        end
        n_ops = $urandom_range(2, 14);
        repeat (n_ops) begin
          pick = $urandom_range(0, 99);
          if (pick < 45) begin
            queue_cmd(FN_PUSH, rand_value());
            if (live < DEPTH) live++;
          end else if (pick < 65 && live > 0) begin
            queue_cmd(FN_DELETE, rand_value());
            live--;
          end else if (pick < 78) begin
            queue_cmd(FN_REVERSE, rand_value());
          end else if (pick < 95) begin
            queue_cmd(FN_EMIT, rand_value());
          end else begin
            queue_cmd(unused_code(), rand_value());
          end
        end
        queue_cmd(FN_EMIT, rand_value());
      end else begin
        n_ops = $urandom_range(1, 8);
        repeat (n_ops) begin
          case ($urandom_range(0, 4))
            0: queue_cmd(FN_PUSH, rand_value());
            1: queue_cmd(FN_DELETE, rand_value());
            2: queue_cmd(FN_DELETE, rand_value());
            3: queue_cmd(FN_REVERSE, rand_value());
            default: queue_cmd(unused_code(), rand_value());
          endcase
        end
        queue_cmd(FN_EMIT, rand_value());
        queue_cmd(FN_CLEAR, rand_value());
        live = 0;
      end
    end
  endtask

  always @(posedge clk) begin : driver_proc
    logic       next_valid;
    deque_cmd_t cmd;
    int         gap_left;
    bit         burst;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      burst = 1'b0;
    end else begin
      if (in_valid && in_ready) apply_command(in_func, in_value);
      next_valid = in_valid && !in_ready;
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_cmds.size() != 0) begin
          if (pending_cmds[0].hold) begin
            if (pending_results.size() == 0) pending_cmds.delete(0);
          end else begin
            cmd = pending_cmds[0];
            pending_cmds.delete(0);
            in_func <= cmd.func;
            in_value <= cmd.value;
            next_valid = 1'b1;
            if ($urandom_range(0, 29) == 0) burst = !burst;
            gap_left = burst ? 0 : $urandom_range(0, 9);
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  always @(posedge clk) begin : monitor_proc
    deque_result_t exp_res;
    int            stall_left;
    bit            burst;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      burst = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("unexpected result: status %0d element %0d last %0d",
                                    out_status, out_element, out_last));
        end else begin
          exp_res = pending_results[0];
          pending_results.delete(0);
          if (out_status !== exp_res.status) begin
            report_mismatch($sformatf("status %0d, expected %0d", out_status, exp_res.status));
          end
          if (out_element !== exp_res.element) begin
            report_mismatch($sformatf("element %0d, expected %0d", out_element,
                                      exp_res.element));
          end
          if (out_last !== exp_res.last) begin
            report_mismatch($sformatf("last %0d, expected %0d", out_last, exp_res.last));
          end
        end
        if ($urandom_range(0, 29) == 0) burst = !burst;
        stall_left = burst ? 0 : $urandom_range(0, 9);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    build_stimulus();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    while (pending_cmds.size() != 0 || in_valid || pending_results.size() != 0) begin
      @(negedge clk);
    end
    repeat (40) @(negedge clk);
    if (pending_results.size() != 0) report_mismatch("results still outstanding at end of run");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
